>>> design/tod_pkg.sv
package tod_pkg;

	typedef enum logic [1:0] {
		FUNC_SET_NORM,
		FUNC_SET_STRICT,
		FUNC_ADD,
		FUNC_DIFF
	} func_t;

	localparam int S_TDATA_W = 128;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 1;

	localparam logic [31:0] DAY_HOURS = 32'd24;
	localparam logic [31:0] DAY_MINS  = 32'd1440;
	localparam logic [31:0] DAY_SEC   = 32'd86400;
	localparam logic [31:0] HOUR_SEC  = 32'd3600;
	localparam logic [31:0] MIN_SEC   = 32'd60;

	localparam int MAX_HOUR   = 23;
	localparam int MAX_MINSEC = 59;

	localparam logic [31:0] RECIP_24   = 32'((64'd1 << 32) / 64'd24);
	localparam logic [31:0] RECIP_1440 = 32'((64'd1 << 32) / 64'd1440);
	localparam logic [31:0] RECIP_DAY  = 32'((64'd1 << 32) / 64'd86400);
	localparam logic [31:0] RECIP_HOUR = 32'((64'd1 << 32) / 64'd3600);
	localparam logic [31:0] RECIP_MIN  = 32'((64'd1 << 32) / 64'd60);

	localparam logic [31:0] BIAS_24   = 32'((64'd1 << 31) % 64'd24);
	localparam logic [31:0] BIAS_1440 = 32'((64'd1 << 31) % 64'd1440);
	localparam logic [31:0] BIAS_DAY  = 32'((64'd1 << 31) % 64'd86400);

	function automatic logic [31:0] mod_small(input logic [31:0] x, input logic [31:0] d);
		logic [31:0] d2;
		d2 = d << 1;
		if (x < d) begin
			return x;
		end else if (x < d2) begin
			return x - d;
		end else begin
			return x - d2;
		end
	endfunction

	function automatic logic [31:0] recip_q(input logic [31:0] u, input logic [31:0] m);
		logic [63:0] p;
		p = {32'd0, u} * {32'd0, m};
		return p[63:32];
	endfunction

endpackage

>>> design/time_of_day_clock.sv
// 24-hour time-of-day clock, held as seconds of the day and reported as hh:mm:ss.
// Input channel s_axis: one item per operation; s_axis_tuser selects the operation
// (set normalised, set strict, add seconds, difference), s_axis_tdata carries the
// signed hours, minutes, seconds and the signed offset.
// Output channel m_axis: exactly one item per input item, in order: the time held
// after the operation, the difference in seconds, and the strict-set reject flag.
// The result appears on m_axis from the stage-11 registers.
// Throughput is one item per cycle unless the receiver stalls: the block is an
// 11-stage pipeline in which the only loop is the time register, closed by one
// 32-bit add and a wrap compare in stage 7. Modulo reductions of the 32-bit fields
// use reciprocal multiplies spread over stages 2 to 4; the conversion back to hours,
// minutes and seconds uses stages 8 to 11.
// Reset clears all stage valid flags and sets the time to 00:00:00.
// When the receiver stalls, the whole pipeline holds; s_axis_tready is high
// whenever the output register is empty or being taken, so a full pipeline
// keeps accepting while results flow.
module time_of_day_clock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// hour_in, minute_in, second_in, offset
	input  logic [tod_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// func
	input  logic [tod_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hour_out, minute_out, second_out, difference, zero fill
	output logic [tod_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// invalid
	output logic [tod_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import tod_pkg::*;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	logic signed [31:0] hour_in, minute_in, second_in;
	logic               ok_in;

	func_t       func_s1, func_s2, func_s3, func_s4, func_s5, func_s6;
	logic        ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic [31:0] uh_s1, um_s1, us_s1, uo_s1;
	logic [31:0] uh_s2, um_s2, us_s2, uo_s2;
	logic [31:0] qh_s2, qm_s2, qs_s2, qo_s2;
	logic [16:0] st_s2, st_s3, st_s4, st_s5, st_s6;
	logic [31:0] uh_s3, um_s3, us_s3, uo_s3;
	logic [31:0] ph_s3, pm_s3, ps_s3, po_s3;
	logic [4:0]  hr_s4;
	logic [10:0] mr_s4;
	logic [16:0] sr_s4, or_s4, or_s5, or_s6;
	logic [17:0] gsum_s5;
	logic [16:0] g_s6;

	logic [16:0] tod_q, tod_d;
	logic [31:0] add_sum;
	logic [16:0] t_s7, t_s8;
	logic [17:0] diff_s7, diff_s8, diff_s9, diff_s10, diff_s11;
	logic        inv_s7, inv_s8, inv_s9, inv_s10, inv_s11;

	logic [4:0]  hq_s8, hr_s9, hr_s10, hr_s11;
	logic [16:0] r_hour;
	logic [11:0] rem_s9, rem_s10;
	logic [5:0]  mq_s10, mr_s11, sr_s11;
	logic [6:0]  r_min;

	assign adv           = !vld_s11 || m_axis_tready;
	assign s_axis_tready = adv;

	assign hour_in   = signed'(s_axis_tdata[31:0]);
	assign minute_in = signed'(s_axis_tdata[63:32]);
	assign second_in = signed'(s_axis_tdata[95:64]);

	assign ok_in = hour_in >= 0 && hour_in <= MAX_HOUR
		&& minute_in >= 0 && minute_in <= MAX_MINSEC
		&& second_in >= 0 && second_in <= MAX_MINSEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			tod_q   <= '0;
		end else if (adv) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			if (vld_s6) begin
				tod_q <= tod_d;
			end
		end
	end

	// bias signed fields to unsigned by flipping the sign bit
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func_t'(s_axis_tuser);
			ok_s1   <= ok_in;
			uh_s1   <= {~s_axis_tdata[31], s_axis_tdata[30:0]};
			um_s1   <= {~s_axis_tdata[63], s_axis_tdata[62:32]};
			us_s1   <= {~s_axis_tdata[95], s_axis_tdata[94:64]};
			uo_s1   <= {~s_axis_tdata[127], s_axis_tdata[126:96]};

			func_s2 <= func_s1;
			ok_s2   <= ok_s1;
			uh_s2   <= uh_s1;
			um_s2   <= um_s1;
			us_s2   <= us_s1;
			uo_s2   <= uo_s1;
			qh_s2   <= recip_q(uh_s1, RECIP_24);
			qm_s2   <= recip_q(um_s1, RECIP_1440);
			qs_s2   <= recip_q(us_s1, RECIP_DAY);
			qo_s2   <= recip_q(uo_s1, RECIP_DAY);
			st_s2   <= 17'(uh_s1[4:0]) * 17'(HOUR_SEC) + 17'(um_s1[5:0]) * 17'(MIN_SEC)
				+ 17'(us_s1[5:0]);

			func_s3 <= func_s2;
			ok_s3   <= ok_s2;
			st_s3   <= st_s2;
			uh_s3   <= uh_s2;
			um_s3   <= um_s2;
			us_s3   <= us_s2;
			uo_s3   <= uo_s2;
			ph_s3   <= 32'(qh_s2 * DAY_HOURS);
			pm_s3   <= 32'(qm_s2 * DAY_MINS);
			ps_s3   <= 32'(qs_s2 * DAY_SEC);
			po_s3   <= 32'(qo_s2 * DAY_SEC);

			// remainder below twice the divisor; remove the bias modulo the divisor
			func_s4 <= func_s3;
			ok_s4   <= ok_s3;
			st_s4   <= st_s3;
			hr_s4   <= 5'(mod_small(uh_s3 - ph_s3 + DAY_HOURS - BIAS_24, DAY_HOURS));
			mr_s4   <= 11'(mod_small(um_s3 - pm_s3 + DAY_MINS - BIAS_1440, DAY_MINS));
			sr_s4   <= 17'(mod_small(us_s3 - ps_s3 + DAY_SEC - BIAS_DAY, DAY_SEC));
			or_s4   <= 17'(mod_small(uo_s3 - po_s3 + DAY_SEC - BIAS_DAY, DAY_SEC));

			func_s5 <= func_s4;
			ok_s5   <= ok_s4;
			st_s5   <= st_s4;
			or_s5   <= or_s4;
			gsum_s5 <= 18'(hr_s4) * 18'(HOUR_SEC) + 18'(mr_s4) * 18'(MIN_SEC) + 18'(sr_s4);

			func_s6 <= func_s5;
			ok_s6   <= ok_s5;
			st_s6   <= st_s5;
			or_s6   <= or_s5;
			g_s6    <= 17'(mod_small(32'(gsum_s5), DAY_SEC));

			t_s7    <= tod_d;
			diff_s7 <= (func_s6 == FUNC_DIFF) ? 18'(tod_q) - 18'(g_s6) : '0;
			inv_s7  <= (func_s6 == FUNC_SET_STRICT) && !ok_s6;

			t_s8    <= t_s7;
			diff_s8 <= diff_s7;
			inv_s8  <= inv_s7;
			hq_s8   <= 5'(recip_q(32'(t_s7), RECIP_HOUR));

			diff_s9 <= diff_s8;
			inv_s9  <= inv_s8;
			if (r_hour >= 17'(HOUR_SEC)) begin
				hr_s9  <= hq_s8 + 5'd1;
				rem_s9 <= 12'(r_hour - 17'(HOUR_SEC));
			end else begin
				hr_s9  <= hq_s8;
				rem_s9 <= 12'(r_hour);
			end

			diff_s10 <= diff_s9;
			inv_s10  <= inv_s9;
			hr_s10   <= hr_s9;
			rem_s10  <= rem_s9;
			mq_s10   <= 6'(recip_q(32'(rem_s9), RECIP_MIN));

			diff_s11 <= diff_s10;
			inv_s11  <= inv_s10;
			hr_s11   <= hr_s10;
			if (r_min >= 7'(MIN_SEC)) begin
				mr_s11 <= mq_s10 + 6'd1;
				sr_s11 <= 6'(r_min - 7'(MIN_SEC));
			end else begin
				mr_s11 <= mq_s10;
				sr_s11 <= 6'(r_min);
			end
		end
	end

	assign add_sum = 32'(tod_q) + 32'(or_s6);

	always_comb begin
		case (func_s6)
			FUNC_SET_NORM: begin
				tod_d = g_s6;
			end
			FUNC_SET_STRICT: begin
				tod_d = ok_s6 ? st_s6 : tod_q;
			end
			FUNC_ADD: begin
				tod_d = 17'(mod_small(add_sum, DAY_SEC));
			end
			default: begin
				tod_d = tod_q;
			end
		endcase
	end

	assign r_hour = t_s8 - 17'(hq_s8) * 17'(HOUR_SEC);
	assign r_min  = 7'(rem_s10 - 12'(mq_s10) * 12'(MIN_SEC));

	assign m_axis_tvalid = vld_s11;
	assign m_axis_tdata  = {5'd0, diff_s11, sr_s11, mr_s11, hr_s11};
	assign m_axis_tuser  = inv_s11;

endmodule
